// ----- rtl/bpr_pkg.sv -----
// Shared types, constants and byte helpers for the piece bitmap selector.
`timescale 1ns / 1ps

package bpr_pkg;

   // Default bitmap depth in bytes
   localparam int BPR_MAX_BYTES = 128;

   // Field widths
   localparam int PIECE_W = 10;
   localparam int POS_W   = 7;
   localparam int RND_W   = 16;
   localparam int CNT_W   = 11;   // obtainable count, at most 255 bytes of 8 bits
   localparam int STEP_W  = 4;    // one remainder bit per step over RND_W bits

   typedef enum logic [2:0] {
      OP_SET   = 3'd0,
      OP_CLEAR = 3'd1,
      OP_PEER  = 3'd2,
      OP_PICK  = 3'd3,
      OP_FIND  = 3'd4
   } bpr_op_type;

   typedef enum logic [1:0] {
      STS_DONE  = 2'd0,
      STS_FOUND = 2'd1,
      STS_NONE  = 2'd2,
      STS_RANGE = 2'd3
   } bpr_status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HAVE_RD,
      ST_HAVE_WR,
      ST_PEER_WR,
      ST_COUNT,
      ST_MOD,
      ST_SEARCH,
      ST_FIND,
      ST_RESULT
   } bpr_state_type;

   // Bitmap RAM strobes
   typedef struct packed {
      logic rd_en;
      logic have_we;
      logic peer_we;
   } bpr_ram_ctl_type;

   // Number of set bits in a byte
   function automatic logic [3:0] bpr_pop8(input logic [7:0] v);
      logic [3:0] n;
      n = '0;
      for (int j = 0; j < 8; j++) begin
         n = n + {3'b000, v[j]};
      end
      return n;
   endfunction

   // Position, counted from the MSB, of the first set bit
   function automatic logic [2:0] bpr_first_set(input logic [7:0] v);
      logic [2:0] p;
      logic       hit;
      p   = '0;
      hit = 1'b0;
      for (int j = 0; j < 8; j++) begin
         if (v[7 - j] && !hit) begin
            p   = 3'(j);
            hit = 1'b1;
         end
      end
      return p;
   endfunction

   // Position, counted from the MSB, of the set bit of rank k (rank 0 first)
   function automatic logic [2:0] bpr_rank_sel(input logic [7:0] v, input logic [2:0] k);
      logic [3:0] seen;
      logic [2:0] p;
      logic       hit;
      seen = '0;
      p    = '0;
      hit  = 1'b0;
      for (int j = 0; j < 8; j++) begin
         if (v[7 - j] && !hit) begin
            if (seen == {1'b0, k}) begin
               p   = 3'(j);
               hit = 1'b1;
            end else begin
               seen = seen + 4'd1;
            end
         end
      end
      return p;
   endfunction

endpackage

// ----- rtl/bpr_bitmap_ram.sv -----
// Have and peer bitmap memories sharing one address, with registered read data.
`timescale 1ns / 1ps

module bpr_bitmap_ram import bpr_pkg::*; #(
   parameter int MAX_BYTES = BPR_MAX_BYTES,
   parameter int AW        = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
   input  logic            clock,
   input  bpr_ram_ctl_type ram_ctl,
   input  logic [AW-1:0]   addr,
   input  logic [7:0]      wr_have,
   input  logic [7:0]      wr_peer,
   output logic [7:0]      rd_have,
   output logic [7:0]      rd_peer
);

   logic [7:0] have_mem [MAX_BYTES];
   logic [7:0] peer_mem [MAX_BYTES];

   // Write either map
   always_ff @(posedge clock) begin
      if (ram_ctl.have_we) begin
         have_mem[addr] <= wr_have;
      end
      if (ram_ctl.peer_we) begin
         peer_mem[addr] <= wr_peer;
      end
   end

   // Read both maps at the same byte
   always_ff @(posedge clock) begin
      if (ram_ctl.rd_en) begin
         rd_have <= have_mem[addr];
         rd_peer <= peer_mem[addr];
      end
   end

endmodule

// ----- rtl/bpr_mod_unit.sv -----
// Bit-serial remainder unit: random value modulo obtainable count, one bit a cycle.
`timescale 1ns / 1ps

module bpr_mod_unit import bpr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [RND_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [CNT_W-1:0] remainder
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [RND_W-1:0]  dvd_ff, dvd_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W:0]    trial;

   // Shift in the next dividend bit and subtract where it fits
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[RND_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[CNT_W-1:0];
         end
         dvd_in  = {dvd_ff[RND_W-2:0], 1'b0};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(RND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/piece_bitmap_random_select.sv -----
// Top level: sequencer over the bitmap memories and the remainder unit.
//
// Piece bitmap selector. Each word on the req channel carries one operation in
// req_tuser (set or clear a held piece, write a peer byte, pick a random
// obtainable piece, find the first held piece the peer lacks); each produces
// exactly one word on the rsp channel with a status in rsp_tuser and a piece
// index in rsp_tdata. The csr channel writes the number of bitmap bytes in use;
// write it only while no operation is in flight.
// One operation is in work at a time; req_tready is low until it is finished.
// Steps from acceptance to rsp_tvalid, with n bytes in use:
//   set / clear: read, modify, write through the single RAM port
//   peer write: one write; range errors and unused opcodes: result only
//   find: a scan of at most n bytes (one byte read per cycle)
//   pick: count scan, bit-serial remainder, select scan
// The bitmap RAM port and the bit-serial remainder unit set the pace of each step.
// After reset a pass over all MAX_BYTES bytes clears both bitmaps, one byte a
// cycle, while req_tready stays low; csr writes are taken throughout.
// A result waits in the rsp register while rsp_tready is low; one more word is
// still taken, but its result holds the block until the register is free again.
`timescale 1ns / 1ps

module piece_bitmap_random_select import bpr_pkg::*; #(
   parameter int MAX_BYTES = BPR_MAX_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   // request words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // piece_number[9:0], byte_position[16:10],
                                    // byte_value[24:17], random_value[40:25], zeros
   input  logic [2:0]  req_tuser,   // opcode[2:0]
   // response words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // found_piece[9:0], zeros
   output logic [1:0]  rsp_tuser,   // status[1:0]
   // bitmap size register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int AW    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int IW    = (AW > 8) ? AW : 8;
   localparam int LIM   = (MAX_BYTES > 255) ? 255 : MAX_BYTES;
   localparam logic [7:0] LIM_B = 8'(LIM);

   bpr_state_type    state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [7:0]       bb_ff, bb_in;
   logic [2:0]       op_ff, op_in;
   logic [PIECE_W-1:0] piece_ff, piece_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       val_ff, val_in;
   logic [RND_W-1:0] rnd_ff, rnd_in;
   logic [7:0]       iss_ff, iss_in;
   logic [7:0]       idx_ff, idx_in;
   logic             dv_ff, dv_in;
   logic [CNT_W-1:0] acc_ff, acc_in;
   bpr_status_type   res_sts_ff, res_sts_in;
   logic [PIECE_W-1:0] res_piece_ff, res_piece_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_sts_ff, rsp_sts_in;
   logic [PIECE_W-1:0] rsp_piece_ff, rsp_piece_in;

   logic [7:0]       n_bytes;
   logic [PIECE_W-1:0] req_piece;
   logic [POS_W-1:0] req_pos;
   logic [6:0]       req_byte;
   logic [IW-1:0]    iss_wide, piece_wide, pos_wide;
   logic [7:0]       piece_mask;

   bpr_ram_ctl_type  ram_ctl;
   logic [AW-1:0]    ram_addr;
   logic [7:0]       ram_wr_have, ram_wr_peer, rd_have, rd_peer;
   logic [7:0]       obtain_byte, unrep_byte;
   logic [3:0]       obtain_pop;
   logic             scan_end;
   logic             mod_start, mod_done;
   logic [CNT_W-1:0] mod_rem;
   logic [10:0]      hit_index;

   // Bytes in use, saturated to the memory depth
   assign n_bytes = (bb_ff > LIM_B) ? LIM_B : bb_ff;

   assign req_piece = req_tdata[9:0];
   assign req_pos   = req_tdata[16:10];
   assign req_byte  = req_piece[9:3];

   assign iss_wide   = IW'(iss_ff);
   assign piece_wide = IW'(piece_ff[9:3]);
   assign pos_wide   = IW'(pos_ff);
   assign piece_mask = 8'h80 >> piece_ff[2:0];

   assign obtain_byte = rd_peer & ~rd_have;
   assign unrep_byte  = rd_have & ~rd_peer;
   assign obtain_pop  = bpr_pop8(obtain_byte);
   assign scan_end    = (iss_ff >= n_bytes) && !dv_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   // Sequencer: next state, RAM strobes and result
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      piece_in     = piece_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      rnd_in       = rnd_ff;
      iss_in       = iss_ff;
      idx_in       = idx_ff;
      dv_in        = 1'b0;
      acc_in       = acc_ff;
      res_sts_in   = res_sts_ff;
      res_piece_in = res_piece_ff;
      ram_ctl      = '0;
      ram_addr     = iss_wide[AW-1:0];
      ram_wr_have  = '0;
      ram_wr_peer  = '0;
      mod_start    = 1'b0;
      hit_index    = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_ctl.have_we = 1'b1;
            ram_ctl.peer_we = 1'b1;
            ram_addr        = clr_ff;
            clr_in          = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_tvalid) begin
               op_in        = req_tuser;
               piece_in     = req_piece;
               pos_in       = req_pos;
               val_in       = req_tdata[24:17];
               rnd_in       = req_tdata[40:25];
               iss_in       = '0;
               acc_in       = '0;
               res_sts_in   = STS_RANGE;
               res_piece_in = '0;
               state_in     = ST_RESULT;
               unique case (req_tuser) inside
                  OP_SET, OP_CLEAR: begin
                     if ({1'b0, req_byte} < n_bytes) begin
                        state_in = ST_HAVE_RD;
                     end
                  end
                  OP_PEER: begin
                     if ({1'b0, req_pos} < n_bytes) begin
                        state_in = ST_PEER_WR;
                     end
                  end
                  OP_PICK: state_in = ST_COUNT;
                  OP_FIND: state_in = ST_FIND;
                  default: state_in = ST_RESULT;
               endcase
            end
         end

         ST_HAVE_RD: begin
            ram_ctl.rd_en = 1'b1;
            ram_addr      = piece_wide[AW-1:0];
            state_in      = ST_HAVE_WR;
         end

         ST_HAVE_WR: begin
            ram_ctl.have_we = 1'b1;
            ram_addr        = piece_wide[AW-1:0];
            ram_wr_have     = (op_ff == OP_SET) ? (rd_have | piece_mask)
                                                : (rd_have & ~piece_mask);
            res_sts_in      = STS_DONE;
            state_in        = ST_RESULT;
         end

         ST_PEER_WR: begin
            ram_ctl.peer_we = 1'b1;
            ram_addr        = pos_wide[AW-1:0];
            ram_wr_peer     = val_ff;
            res_sts_in      = STS_DONE;
            state_in        = ST_RESULT;
         end

         ST_COUNT: begin
            // Stream bytes and add up obtainable bits
            ram_ctl.rd_en = (iss_ff < n_bytes);
            if (ram_ctl.rd_en) begin
               iss_in = iss_ff + 8'd1;
            end
            dv_in  = ram_ctl.rd_en;
            idx_in = iss_ff;
            if (dv_ff) begin
               acc_in = acc_ff + CNT_W'(obtain_pop);
            end
            if (scan_end) begin
               if (acc_ff == '0) begin
                  res_sts_in = STS_NONE;
                  state_in   = ST_RESULT;
               end else begin
                  mod_start = 1'b1;
                  state_in  = ST_MOD;
               end
            end
         end

         ST_MOD: begin
            if (mod_done) begin
               acc_in   = mod_rem;
               iss_in   = '0;
               state_in = ST_SEARCH;
            end
         end

         ST_SEARCH: begin
            // Step over whole bytes until the target rank falls inside one
            ram_ctl.rd_en = (iss_ff < n_bytes);
            if (ram_ctl.rd_en) begin
               iss_in = iss_ff + 8'd1;
            end
            dv_in  = ram_ctl.rd_en;
            idx_in = iss_ff;
            if (dv_ff) begin
               if (acc_ff < CNT_W'(obtain_pop)) begin
                  hit_index    = {idx_ff, bpr_rank_sel(obtain_byte, acc_ff[2:0])};
                  res_piece_in = hit_index[PIECE_W-1:0];
                  res_sts_in   = STS_FOUND;
                  state_in     = ST_RESULT;
               end else begin
                  acc_in = acc_ff - CNT_W'(obtain_pop);
               end
            end else if (scan_end) begin
               res_sts_in = STS_NONE;
               state_in   = ST_RESULT;
            end
         end

         ST_FIND: begin
            // First byte holding a held piece the peer does not report
            ram_ctl.rd_en = (iss_ff < n_bytes);
            if (ram_ctl.rd_en) begin
               iss_in = iss_ff + 8'd1;
            end
            dv_in  = ram_ctl.rd_en;
            idx_in = iss_ff;
            if (dv_ff && (unrep_byte != 8'd0)) begin
               hit_index    = {idx_ff, bpr_first_set(unrep_byte)};
               res_piece_in = hit_index[PIECE_W-1:0];
               res_sts_in   = STS_FOUND;
               state_in     = ST_RESULT;
            end else if (scan_end) begin
               res_sts_in = STS_NONE;
               state_in   = ST_RESULT;
            end
         end

         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Output register: load a finished result, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sts_in   = rsp_sts_ff;
      rsp_piece_in = rsp_piece_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_in = 1'b1;
         rsp_sts_in   = res_sts_ff;
         rsp_piece_in = res_piece_ff;
      end
   end

   // Hold the size register
   always_comb begin
      bb_in = bb_ff;
      if (csr_valid) begin
         bb_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         bb_ff        <= 8'd1;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         bb_ff        <= bb_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      piece_ff     <= piece_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      rnd_ff       <= rnd_in;
      iss_ff       <= iss_in;
      idx_ff       <= idx_in;
      acc_ff       <= acc_in;
      res_sts_ff   <= res_sts_in;
      res_piece_ff <= res_piece_in;
      rsp_sts_ff   <= rsp_sts_in;
      rsp_piece_ff <= rsp_piece_in;
   end

   bpr_bitmap_ram #(
      .MAX_BYTES (MAX_BYTES),
      .AW        (AW)
   ) u_ram (
      .clock   (clock),
      .ram_ctl (ram_ctl),
      .addr    (ram_addr),
      .wr_have (ram_wr_have),
      .wr_peer (ram_wr_peer),
      .rd_have (rd_have),
      .rd_peer (rd_peer)
   );

   bpr_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (rnd_ff),
      .divisor   (acc_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_piece_ff};
   assign rsp_tuser  = rsp_sts_ff;

endmodule
